// File: design/lcdnx_pkg.sv
// ----------------------------------------------------------------------------
// lcdnx_pkg
// Shared types, constants and small tables for the 4-bit character LCD
// command expander.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnx_pkg;

   // Request type codes.
   localparam logic [2:0] REQ_INIT   = 3'd0;
   localparam logic [2:0] REQ_CLEAR  = 3'd1;
   localparam logic [2:0] REQ_WRITE  = 3'd2;
   localparam logic [2:0] REQ_CURSOR = 3'd3;
   localparam logic [2:0] REQ_RAW    = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_POWER_UP = 2'd0;
   localparam logic [1:0] CSR_SETTLE   = 2'd1;
   localparam logic [1:0] CSR_CLEAR    = 2'd2;

   // Register reset values.
   localparam logic [15:0] POWER_UP_RESET = 16'd20000;
   localparam logic [7:0]  SETTLE_RESET   = 8'd37;
   localparam logic [15:0] CLEAR_RESET    = 16'd2000;

   // Fixed waits before the second and third wake-up nibbles.
   localparam logic [15:0] WAKE2_WAIT_US = 16'd5000;
   localparam logic [15:0] WAKE3_WAIT_US = 16'd100;
   localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

   // Command bytes.
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

   // Last step index of the init and byte sequences.
   localparam int STEP_W       = 4;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One classified job as handed from front to back.
   typedef struct packed {
      logic       is_init;
      logic       clr_extra;
      logic       rs;
      logic [7:0] data;
   } job_type;

   // One nibble transfer.
   typedef struct packed {
      logic [3:0]  nibble;
      logic        reg_select;
      logic [15:0] wait_before_us;
      logic [15:0] wait_after_us;
      logic        last;
   } rsp_type;

   // Nibbles of the init run: wake-up 3,3,3,2 then 0x28, 0x0C, 0x06, 0x01.
   function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
      logic [3:0] nib;
      case (step)
         4'd0:    nib = 4'h3;
         4'd1:    nib = 4'h3;
         4'd2:    nib = 4'h3;
         4'd3:    nib = 4'h2;
         4'd4:    nib = 4'h2;
         4'd5:    nib = 4'h8;
         4'd6:    nib = 4'h0;
         4'd7:    nib = 4'hC;
         4'd8:    nib = 4'h0;
         4'd9:    nib = 4'h6;
         4'd10:   nib = 4'h0;
         4'd11:   nib = 4'h1;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

   // Display RAM base address of each row.
   function automatic logic [6:0] row_base(input logic [1:0] row);
      logic [6:0] base;
      case (row)
         2'd0:    base = 7'h00;
         2'd1:    base = 7'h40;
         2'd2:    base = 7'h14;
         2'd3:    base = 7'h54;
         default: base = 7'h00;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// File: design/lcdnx_front.sv
// ----------------------------------------------------------------------------
// lcdnx_front
// Classifies an accepted request into a job for the sequencer and drops
// unknown request types.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnx_front
   import lcdnx_pkg::*;
(
   input  wire logic       accept,
   input  wire logic [2:0] req_type,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [1:0] req_row,
   input  wire logic [6:0] req_col,
   output logic            push,
   output job_type         job
);

   logic [6:0] cursor_addr;

   // Cursor address wraps within seven bits.
   assign cursor_addr = row_base(req_row) + req_col;

   // Decode the request type into a job.
   always_comb begin
      push = 1'b0;
      job  = '0;
      case (req_type)
         REQ_INIT: begin
            push          = accept;
            job.is_init   = 1'b1;
            job.clr_extra = 1'b1;
         end
         REQ_CLEAR: begin
            push          = accept;
            job.clr_extra = 1'b1;
            job.data      = CMD_CLEAR;
         end
         REQ_WRITE: begin
            push     = accept;
            job.rs   = 1'b1;
            job.data = req_byte_value;
         end
         REQ_CURSOR: begin
            push     = accept;
            job.data = CMD_SET_DDRAM | {1'b0, cursor_addr};
         end
         REQ_RAW: begin
            push     = accept;
            job.data = req_byte_value;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/lcdnx_queue.sv
// ----------------------------------------------------------------------------
// lcdnx_queue
// Small first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnx_queue
   import lcdnx_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         not_empty,
   output logic         full,
   output job_type      head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_FULL);
   assign head_job  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: design/lcdnx_back.sv
// ----------------------------------------------------------------------------
// lcdnx_back
// Sequencer that plays one job out as a run of nibble transfers, one per
// cycle, into a registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnx_back
   import lcdnx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_not_empty,
   input  wire job_type     q_job,
   output logic             pop,
   input  wire logic [15:0] power_up_wait_us,
   input  wire logic [7:0]  settle_us,
   input  wire logic [15:0] clear_wait_us,
   output logic             rsp_valid,
   output rsp_type          rsp
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              step_last;
   logic [16:0]       clear_sum;

   assign step_last = job_ff.is_init ? (step_ff == INIT_LAST_STEP)
                                     : (step_ff == BYTE_LAST_STEP);
   assign clear_sum = {9'd0, settle_us} + {1'b0, clear_wait_us};

   // Take the next job when idle or on the final step of the current one.
   assign pop = q_not_empty && ((state_ff == ST_IDLE) || step_last);

   // Build the transfer for the current step.
   always_comb begin
      rsp_in                = '0;
      rsp_in.reg_select     = job_ff.rs;
      rsp_in.last           = step_last;
      rsp_in.wait_after_us  = {8'd0, settle_us};
      if (job_ff.is_init) begin
         rsp_in.nibble = init_nibble(step_ff);
      end else if (step_ff == '0) begin
         rsp_in.nibble = job_ff.data[7:4];
      end else begin
         rsp_in.nibble = job_ff.data[3:0];
      end
      if (job_ff.is_init) begin
         case (step_ff)
            4'd0:    rsp_in.wait_before_us = power_up_wait_us;
            4'd1:    rsp_in.wait_before_us = WAKE2_WAIT_US;
            4'd2:    rsp_in.wait_before_us = WAKE3_WAIT_US;
            default: rsp_in.wait_before_us = '0;
         endcase
      end
      if (step_last && job_ff.clr_extra) begin
         rsp_in.wait_after_us = clear_sum[16] ? WAIT_MAX : clear_sum[15:0];
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      step_in  = step_ff;
      if (pop) begin
         state_in = ST_RUN;
         job_in   = q_job;
         step_in  = '0;
      end else if (state_ff == ST_RUN) begin
         if (step_last) begin
            state_in = ST_IDLE;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   // State and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_RUN);
      end
      job_ff  <= job_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: design/char_lcd_nibble_command_expander_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_expander_top
// Expands LCD requests (init, clear, write, cursor move, raw command) into
// nibble transfers for a 4-bit character LCD bus.
//
//   Channel   Ports                  Handshake
//   request   start, busy, req_*     taken when start high and busy low
//   result    rsp_valid, rsp_*       one transfer per valid cycle, no back-pressure
//   config    psel..pready, paddr    APB write/read, pready tied high
//
// A byte request gives two transfers on back-to-back cycles; init gives
// twelve. A request passes the queue, then the sequencer state, then the
// result register. The sequencer emits one transfer per cycle and pops
// the next job on the last step. busy rises only while the queue is full.
// Reset is synchronous and presets the queue, sequencer and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_command_expander_top
   import lcdnx_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [1:0]  req_row,
   input  wire logic [6:0]  req_col,
   // Result channel.
   output logic             rsp_valid,
   output logic [3:0]       rsp_nibble,
   output logic             rsp_reg_select,
   output logic [15:0]      rsp_wait_before_us,
   output logic [15:0]      rsp_wait_after_us,
   output logic             rsp_last,
   // Configuration port.
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0] power_up_ff;
   logic [7:0]  settle_ff;
   logic [15:0] clear_ff;
   logic        csr_write;
   logic        accept;
   logic        push;
   job_type     push_job;
   logic        pop;
   logic        q_not_empty;
   logic        q_full;
   job_type     head_job;
   rsp_type     rsp;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_up_ff <= POWER_UP_RESET;
         settle_ff   <= SETTLE_RESET;
         clear_ff    <= CLEAR_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            CSR_POWER_UP: power_up_ff <= pwdata[15:0];
            CSR_SETTLE:   settle_ff   <= pwdata[7:0];
            CSR_CLEAR:    clear_ff    <= pwdata[15:0];
            default:      ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         CSR_POWER_UP: prdata = {16'd0, power_up_ff};
         CSR_SETTLE:   prdata = {24'd0, settle_ff};
         CSR_CLEAR:    prdata = {16'd0, clear_ff};
         default:      prdata = '0;
      endcase
   end

   // Request acceptance.
   assign busy   = q_full;
   assign accept = start && !busy;

   lcdnx_front u_front (
      .accept         (accept),
      .req_type       (req_type),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .push           (push),
      .job            (push_job)
   );

   lcdnx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head_job  (head_job)
   );

   lcdnx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_job            (head_job),
      .pop              (pop),
      .power_up_wait_us (power_up_ff),
      .settle_us        (settle_ff),
      .clear_wait_us    (clear_ff),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp)
   );

   assign rsp_nibble         = rsp.nibble;
   assign rsp_reg_select     = rsp.reg_select;
   assign rsp_wait_before_us = rsp.wait_before_us;
   assign rsp_wait_after_us  = rsp.wait_after_us;
   assign rsp_last           = rsp.last;

`ifndef SYNTH
   // A run of transfers is never broken by an idle cycle.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("transfer run interrupted before its last nibble");

   // The wait after enable never falls below the settle time.
   a_after_ge_settle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wait_after_us >= {8'd0, settle_ff})
      else $error("wait after enable below settle time");

   // Only init wake-up nibbles carry a wait before; they go to the command
   // register.
   a_before_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wait_before_us != 16'd0 |-> !rsp_reg_select)
      else $error("wait before enable on a data transfer");
`endif

endmodule

`default_nettype wire
